>>> hdl/env_sensor_compensation_macros.svh
// Assertion helpers used by the esc_back RTL file of the compensation block.
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/esc_pkg.sv
package esc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TEMP,
        CFG_PRES_LOW,
        CFG_PRES_HIGH,
        CFG_PRES_LAST,
        CFG_HUM_A,
        CFG_HUM_B
    } cfg_index_t;

    localparam logic [63:0] T_FINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRES_FULL     = 64'd1048576;
    localparam logic [63:0] PRES_SCALE    = 64'd3125;
    localparam logic [63:0] PRES_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [31:0] HUM_OFFSET    = 32'd76800;
    localparam logic [31:0] HUM_BIAS      = 32'd2097152;
    localparam logic [31:0] HUM_MAX       = 32'd419430400;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
        logic               pressure_invalid;
    } result_t;

    typedef struct packed {
        logic [47:0]        temp_coeffs;
        logic [63:0]        pres_coeffs_low;
        logic [63:0]        pres_coeffs_high;
        logic signed [15:0] pres_coeff_last;
        logic [39:0]        hum_coeffs_a;
        logic [31:0]        hum_coeffs_b;
    } coeff_t;

    typedef struct packed {
        logic [31:0] t_lin;
        logic [31:0] t_diff;
        logic [63:0] p_num;
        logic [31:0] h_base;
    } fe_item_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
        return $signed(x) >>> s;
    endfunction

endpackage

>>> hdl/esc_front.sv
module esc_front #(
    parameter int DEPTH = esc_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  esc_pkg::sample_t  sample,
    input  esc_pkg::coeff_t   coeffs,
    output logic              head_valid,
    output esc_pkg::fe_item_t head,
    input  logic              pop
);
    import esc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fe_item_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    fe_item_t         prep;
    logic             push;
    logic [15:0]      t1;
    logic [15:0]      h4;

    assign t1 = coeffs.temp_coeffs[15:0];
    assign h4 = coeffs.hum_coeffs_b[15:0];

    always_comb
    begin
        prep.t_lin  = {15'd0, sample.raw_temperature[19:3]} - {15'd0, t1, 1'b0};
        prep.t_diff = {16'd0, sample.raw_temperature[19:4]} - {16'd0, t1};
        prep.p_num  = (PRES_FULL - {44'd0, sample.raw_pressure}) << 31;
        prep.h_base = {2'd0, sample.raw_humidity, 14'd0} - {h4[11:0], 20'd0} + 32'd16384;
    end

    assign sample_stall = (count_reg == CNT_W'(DEPTH));
    assign push         = sample_valid && !sample_stall;
    assign head_valid   = (count_reg != '0);
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= prep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/esc_mul.sv
module esc_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);
    import esc_pkg::*;

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [1:0]  phase_reg;
    logic        done_reg;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] partial;

    always_comb
    begin
        case (phase_reg)
            2'd2:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            2'd3:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
            default:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
        endcase
        partial = mul_x * mul_y;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (phase_reg == 2'd1)
        begin
            acc_reg <= partial;
        end
        else if (phase_reg != 2'd0)
        begin
            acc_reg <= acc_reg + {partial[31:0], 32'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (phase_reg == 2'd3);
            if (start)
            begin
                phase_reg <= 2'd1;
            end
            else if (phase_reg == 2'd3)
            begin
                phase_reg <= 2'd0;
            end
            else if (phase_reg != 2'd0)
            begin
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> hdl/esc_div.sv
module esc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import esc_pkg::*;

    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dvs_reg;
    logic        neg_reg;
    logic [6:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        fits;

    assign trial = {rem_reg[62:0], quo_reg[63]};
    assign fits  = (trial >= dvs_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[63] ? 64'd0 - dividend : dividend;
            dvs_reg <= divisor[63] ? 64'd0 - divisor : divisor;
            neg_reg <= dividend[63] ^ divisor[63];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial - dvs_reg : trial;
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == 7'd63);
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 7'd1;
                if (count_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 64'd0 - quo_reg : quo_reg;

endmodule

>>> hdl/esc_back.sv
`include "env_sensor_compensation_macros.svh"

module esc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  esc_pkg::coeff_t   coeffs,
    input  logic              head_valid,
    input  esc_pkg::fe_item_t head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output esc_pkg::result_t  result
);
    import esc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_T0, ST_T1, ST_T2,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
        ST_DIV,
        ST_P7, ST_P8, ST_P9,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7,
        ST_OUT
    } state_t;

    state_t      state_reg;
    logic        issued_reg;
    fe_item_t    cur_reg;
    logic [31:0] ta_reg;
    logic [31:0] s_reg;
    logic [31:0] tf_reg;
    logic [31:0] temp_reg;
    logic [63:0] v1_reg;
    logic [63:0] vv_reg;
    logic [63:0] v2_reg;
    logic [63:0] w_reg;
    logic [63:0] den_reg;
    logic [63:0] num_reg;
    logic [63:0] q_reg;
    logic [63:0] qq_reg;
    logic [63:0] e1_reg;
    logic [63:0] pres_reg;
    logic        inval_reg;
    logic [31:0] hx_reg;
    logic [31:0] lft_reg;
    logic [31:0] r1_reg;
    logic [31:0] r2_reg;
    logic [31:0] rg_reg;
    logic [31:0] xh_reg;
    logic [31:0] y_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic [63:0] op_a;
    logic [63:0] op_b;
    logic        mul_state;
    logic        mul_start;
    logic        mul_done;
    logic [63:0] prod;
    logic        div_start;
    logic        div_done;
    logic [63:0] div_q;
    logic [31:0] tf_new;
    logic [31:0] hum_pre;
    logic [31:0] hum_clamped;
    logic        out_free;

    always_comb
    begin
        mul_state = 1'b1;
        op_a      = '0;
        op_b      = '0;
        case (state_reg)
            ST_T0: begin op_a = {32'd0, cur_reg.t_lin};  op_b = sx16(coeffs.temp_coeffs[31:16]); end
            ST_T1: begin op_a = {32'd0, cur_reg.t_diff}; op_b = {32'd0, cur_reg.t_diff}; end
            ST_T2: begin op_a = {32'd0, s_reg};  op_b = sx16(coeffs.temp_coeffs[47:32]); end
            ST_P0: begin op_a = v1_reg; op_b = v1_reg; end
            ST_P1: begin op_a = vv_reg; op_b = sx16(coeffs.pres_coeffs_high[31:16]); end
            ST_P2: begin op_a = v1_reg; op_b = sx16(coeffs.pres_coeffs_high[15:0]); end
            ST_P3: begin op_a = vv_reg; op_b = sx16(coeffs.pres_coeffs_low[47:32]); end
            ST_P4: begin op_a = v1_reg; op_b = sx16(coeffs.pres_coeffs_low[31:16]); end
            ST_P5: begin op_a = PRES_BIAS + w_reg; op_b = {48'd0, coeffs.pres_coeffs_low[15:0]}; end
            ST_P6: begin op_a = cur_reg.p_num - v2_reg; op_b = PRES_SCALE; end
            ST_P7: begin op_a = asr64(q_reg, 13); op_b = asr64(q_reg, 13); end
            ST_P8: begin op_a = sx16(coeffs.pres_coeff_last); op_b = qq_reg; end
            ST_P9: begin op_a = sx16(coeffs.pres_coeffs_high[63:48]); op_b = q_reg; end
            ST_H0: begin op_a = sx16(coeffs.hum_coeffs_b[31:16]); op_b = {32'd0, hx_reg}; end
            ST_H1: begin op_a = {32'd0, hx_reg}; op_b = sx8(coeffs.hum_coeffs_a[39:32]); end
            ST_H2: begin op_a = {32'd0, hx_reg}; op_b = {56'd0, coeffs.hum_coeffs_a[31:24]}; end
            ST_H3: begin op_a = {32'd0, r1_reg}; op_b = {32'd0, r2_reg}; end
            ST_H4: begin op_a = {32'd0, rg_reg}; op_b = sx16(coeffs.hum_coeffs_a[23:8]); end
            ST_H5: begin op_a = {32'd0, lft_reg}; op_b = {32'd0, rg_reg}; end
            ST_H6: begin op_a = {32'd0, asr32(xh_reg, 15)}; op_b = {32'd0, asr32(xh_reg, 15)}; end
            ST_H7: begin op_a = {32'd0, y_reg}; op_b = {56'd0, coeffs.hum_coeffs_a[7:0]}; end
            default: mul_state = 1'b0;
        endcase
    end

    assign mul_start = mul_state && !issued_reg;
    assign div_start = (state_reg == ST_DIV) && !issued_reg;
    assign out_free  = !out_valid_reg || !result_stall;
    assign pop       = (state_reg == ST_IDLE) && head_valid;

    assign tf_new      = ta_reg + asr32(prod[31:0], 14);
    assign hum_pre     = xh_reg - asr32(prod[31:0], 4);
    assign hum_clamped = hum_pre[31] ? 32'd0 : ((hum_pre > HUM_MAX) ? HUM_MAX : hum_pre);

    esc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (op_a),
        .b       (op_b),
        .done    (mul_done),
        .product (prod)
    );

    esc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (mul_done)
        begin
            case (state_reg)
                ST_T0: ta_reg <= asr32(prod[31:0], 11);
                ST_T1: s_reg <= asr32(prod[31:0], 12);
                ST_T2:
                begin
                    tf_reg   <= tf_new;
                    temp_reg <= asr32(tf_new + {tf_new[29:0], 2'b00} + 32'd128, 8);
                    v1_reg   <= {{32{tf_new[31]}}, tf_new} - T_FINE_OFFSET;
                    hx_reg   <= tf_new - HUM_OFFSET;
                end
                ST_P0: vv_reg <= prod;
                ST_P1: v2_reg <= prod;
                ST_P2: v2_reg <= v2_reg + (prod << 17)
                                 + (sx16(coeffs.pres_coeffs_low[63:48]) << 35);
                ST_P3: w_reg <= asr64(prod, 8);
                ST_P4: w_reg <= w_reg + (prod << 12);
                ST_P5:
                begin
                    den_reg   <= asr64(prod, 33);
                    inval_reg <= (asr64(prod, 33) == 64'd0);
                    pres_reg  <= '0;
                end
                ST_P6: num_reg <= prod;
                ST_P7: qq_reg <= prod;
                ST_P8: e1_reg <= asr64(prod, 25);
                ST_P9: pres_reg <= asr64(q_reg + e1_reg + asr64(prod, 19), 8)
                                   + (sx16(coeffs.pres_coeffs_high[47:32]) << 4);
                ST_H0: lft_reg <= asr32(cur_reg.h_base - prod[31:0], 15);
                ST_H1: r1_reg <= asr32(prod[31:0], 10);
                ST_H2: r2_reg <= asr32(prod[31:0], 11) + 32'd32768;
                ST_H3: rg_reg <= asr32(prod[31:0], 10) + HUM_BIAS;
                ST_H4: rg_reg <= asr32(prod[31:0] + 32'd8192, 14);
                ST_H5: xh_reg <= prod[31:0];
                ST_H6: y_reg <= asr32(prod[31:0], 7);
                ST_H7: xh_reg <= hum_clamped;
                default: ;
            endcase
        end
        if (div_done)
        begin
            q_reg <= div_q;
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_reg.temperature_centi <= $signed(temp_reg);
            out_reg.pressure_q24_8    <= pres_reg[31:0];
            out_reg.humidity_q22_10   <= xh_reg[28:12];
            out_reg.pressure_invalid  <= inval_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_start || div_start)
            begin
                issued_reg <= 1'b1;
            end
            else if (mul_done || div_done)
            begin
                issued_reg <= 1'b0;
            end

            if (out_valid_reg && !result_stall && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        state_reg <= ST_T0;
                    end
                end
                ST_P5:
                begin
                    if (mul_done)
                    begin
                        state_reg <= (asr64(prod, 33) == 64'd0) ? ST_H0 : ST_P6;
                    end
                end
                ST_P9:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_H0;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_P7;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    if (mul_done)
                    begin
                        state_reg <= state_t'(state_reg + 5'd1);
                    end
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `ESC_ASSERT_NOW(a_mul_done_issued, mul_done, issued_reg && mul_state,
        "Multiplier finished with no operation outstanding.")
    `ESC_ASSERT_NOW(a_div_done_state, div_done, state_reg == ST_DIV,
        "Divider finished outside the divide step.")
    `ESC_ASSERT_NEXT(a_out_blocked, (state_reg == ST_OUT) && out_valid_reg && result_stall,
        (state_reg == ST_OUT) && out_valid_reg,
        "Finished item left the output step while the output was still held.")
    `ESC_ASSERT_NOW(a_pop_idle, pop, (state_reg == ST_IDLE) && !issued_reg,
        "Queue popped while an item was still in progress.")

endmodule

>>> hdl/env_sensor_compensation.sv
// Channel  | Handshake              | Payload
// sample   | sample_valid / stall   | esc_pkg::sample_t (raw readings)
// result   | result_valid / stall   | esc_pkg::result_t (compensated values)
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (coefficient words)
//
// In the back end an item is popped, then runs 21 products on one shared 32x32
// multiplier, a signed divide and an output step, one item at a time. Items whose
// pressure divisor is zero skip the divider and four products.
// The front queue holds QUEUE_DEPTH items; sample_stall rises when it is full.
// Reset is asynchronous and clears the coefficients, queue and sequencer.
// A stalled result holds in the output register while the next item runs.
module env_sensor_compensation #(
    parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  esc_pkg::sample_t                 sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output esc_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [esc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [63:0]                      cfg_data
);
    import esc_pkg::*;

    coeff_t   coeffs_reg;
    logic     head_valid;
    fe_item_t head;
    logic     pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEMP:      coeffs_reg.temp_coeffs      <= cfg_data[47:0];
                CFG_PRES_LOW:  coeffs_reg.pres_coeffs_low  <= cfg_data;
                CFG_PRES_HIGH: coeffs_reg.pres_coeffs_high <= cfg_data;
                CFG_PRES_LAST: coeffs_reg.pres_coeff_last  <= $signed(cfg_data[15:0]);
                CFG_HUM_A:     coeffs_reg.hum_coeffs_a     <= cfg_data[39:0];
                CFG_HUM_B:     coeffs_reg.hum_coeffs_b     <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    esc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .coeffs       (coeffs_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop)
    );

    esc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .coeffs       (coeffs_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
